// ===== hdl/cttok_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cttok_pkg - shared types and constants of the config text tokenizer
// Item structs, token kind codes, scanner and number recogniser states and
// the character classes used by the front end.
// ----------------------------------------------------------------------------
package cttok_pkg;

	localparam int OFFSET_BITS_DEF = 32;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int MAX_TOKENS      = 3;

	// Characters
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_EQUALS = 8'h3D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	typedef enum logic [2:0] {
		KIND_EOF     = 3'd0,
		KIND_ATOM    = 3'd1,
		KIND_STRING  = 3'd2,
		KIND_LBRACE  = 3'd3,
		KIND_RBRACE  = 3'd4,
		KIND_LBRACK  = 3'd5,
		KIND_RBRACK  = 3'd6,
		KIND_EQUALS  = 3'd7
	} kind_t;

	typedef enum logic [3:0] {
		MODE_IDLE    = 4'b0001,
		MODE_COMMENT = 4'b0010,
		MODE_ATOM    = 4'b0100,
		MODE_STRING  = 4'b1000
	} mode_t;

	typedef enum logic [5:0] {
		SHAPE_START = 6'b000001,
		SHAPE_MINUS = 6'b000010,
		SHAPE_INT   = 6'b000100,
		SHAPE_DOT   = 6'b001000,
		SHAPE_FRAC  = 6'b010000,
		SHAPE_BAD   = 6'b100000
	} shape_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       has_byte;
		logic       end_of_source;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  token_kind;
		logic [31:0] start_offset;
		logic [31:0] text_length;
		logic        is_number;
		logic        unterminated;
		logic        last_of_run;
	} out_item_t;

	// All tokens caused by one input item
	typedef struct packed {
		logic [1:0]                     count;
		out_item_t [MAX_TOKENS-1:0]     tok;
	} bundle_t;

	function automatic logic is_space(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
	endfunction

	function automatic logic is_term(input logic [7:0] c);
		return is_space(c) || c == CH_LBRACE || c == CH_RBRACE || c == CH_LBRACK ||
			c == CH_RBRACK || c == CH_EQUALS || c == CH_QUOTE || c == CH_HASH;
	endfunction

	// Advance the -?digits(.digits)? recogniser by one byte
	function automatic shape_t shape_next(input shape_t s, input logic [7:0] c);
		logic digit;
		digit = (c >= CH_ZERO) && (c <= CH_NINE);
		case (s)
			SHAPE_START: return (c == CH_MINUS) ? SHAPE_MINUS : (digit ? SHAPE_INT : SHAPE_BAD);
			SHAPE_MINUS: return digit ? SHAPE_INT : SHAPE_BAD;
			SHAPE_INT:   return digit ? SHAPE_INT : ((c == CH_DOT) ? SHAPE_DOT : SHAPE_BAD);
			SHAPE_DOT:   return digit ? SHAPE_FRAC : SHAPE_BAD;
			SHAPE_FRAC:  return digit ? SHAPE_FRAC : SHAPE_BAD;
			default:     return SHAPE_BAD;
		endcase
	endfunction

endpackage
`default_nettype wire

// ===== hdl/cttok_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cttok_front - byte scanner
// Accepts one source item per cycle while the queue is not full, tracks the
// scan state and offsets, and queues the tokens of the item as one bundle.
// ----------------------------------------------------------------------------
module cttok_front #(
	parameter int OFFSET_BITS = cttok_pkg::OFFSET_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                src_valid,
	output logic                     src_ready,
	input  wire cttok_pkg::in_item_t src_item,
	input  wire logic                full,
	output logic                     push,
	output cttok_pkg::bundle_t       push_data
);

	localparam int EW = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;
	localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

	cttok_pkg::mode_t        mode_q, mode_v;
	cttok_pkg::shape_t       shape_q, shape_v;
	logic [OFFSET_BITS-1:0]  pos_q, pos_v;
	logic [OFFSET_BITS-1:0]  begin_q, begin_v;
	logic [1:0]              n_v;
	cttok_pkg::bundle_t      bundle_v;
	logic                    accept;

	// Clamp an offset to the 32-bit output range
	function automatic logic [31:0] sat32(input logic [OFFSET_BITS-1:0] v);
		logic [EW-1:0] ext;
		ext = EW'(v);
		if (ext > EW'(32'hFFFF_FFFF))
			return 32'hFFFF_FFFF;
		return ext[31:0];
	endfunction

	function automatic cttok_pkg::out_item_t make_tok(
		input cttok_pkg::kind_t      kind,
		input logic [OFFSET_BITS-1:0] start,
		input logic [OFFSET_BITS-1:0] len,
		input logic                  num,
		input logic                  unterm
	);
		cttok_pkg::out_item_t t;
		t.token_kind   = kind;
		t.start_offset = sat32(start);
		t.text_length  = sat32(len);
		t.is_number    = num;
		t.unterminated = unterm;
		t.last_of_run  = 1'b0;
		return t;
	endfunction

	function automatic logic [OFFSET_BITS-1:0] str_len(
		input logic [OFFSET_BITS-1:0] e,
		input logic [OFFSET_BITS-1:0] b
	);
		return (e > b) ? (e - b - OFFSET_BITS'(1)) : '0;
	endfunction

	assign src_ready = !full;
	assign accept    = src_valid && src_ready;

	// Work out the next scan state and the tokens of this item
	always_comb begin
		logic [7:0] c;
		logic       do_idle;
		c        = src_item.text_byte;
		do_idle  = 1'b0;
		mode_v   = mode_q;
		shape_v  = shape_q;
		pos_v    = pos_q;
		begin_v  = begin_q;
		n_v      = 2'd0;
		bundle_v = '0;
		if (src_item.has_byte) begin
			case (mode_q)
				cttok_pkg::MODE_COMMENT: begin
					if (c == cttok_pkg::CH_LF)
						mode_v = cttok_pkg::MODE_IDLE;
				end
				cttok_pkg::MODE_STRING: begin
					if (c == cttok_pkg::CH_QUOTE) begin
						bundle_v.tok[n_v] = make_tok(cttok_pkg::KIND_STRING, begin_q,
							str_len(pos_q, begin_q), 1'b0, 1'b0);
						n_v    = n_v + 2'd1;
						mode_v = cttok_pkg::MODE_IDLE;
					end
				end
				cttok_pkg::MODE_ATOM: begin
					if (cttok_pkg::is_term(c)) begin
						bundle_v.tok[n_v] = make_tok(cttok_pkg::KIND_ATOM, begin_q,
							pos_q - begin_q,
							shape_q == cttok_pkg::SHAPE_INT || shape_q == cttok_pkg::SHAPE_FRAC,
							1'b0);
						n_v     = n_v + 2'd1;
						mode_v  = cttok_pkg::MODE_IDLE;
						do_idle = 1'b1;
					end else begin
						shape_v = cttok_pkg::shape_next(shape_q, c);
					end
				end
				default: do_idle = 1'b1;
			endcase

			// Byte seen between tokens
			if (do_idle && !cttok_pkg::is_space(c)) begin
				case (c)
					cttok_pkg::CH_HASH: mode_v = cttok_pkg::MODE_COMMENT;
					cttok_pkg::CH_QUOTE: begin
						mode_v  = cttok_pkg::MODE_STRING;
						begin_v = pos_q;
					end
					cttok_pkg::CH_LBRACE, cttok_pkg::CH_RBRACE, cttok_pkg::CH_LBRACK,
					cttok_pkg::CH_RBRACK, cttok_pkg::CH_EQUALS: begin
						bundle_v.tok[n_v] = make_tok(
							(c == cttok_pkg::CH_LBRACE) ? cttok_pkg::KIND_LBRACE :
							(c == cttok_pkg::CH_RBRACE) ? cttok_pkg::KIND_RBRACE :
							(c == cttok_pkg::CH_LBRACK) ? cttok_pkg::KIND_LBRACK :
							(c == cttok_pkg::CH_RBRACK) ? cttok_pkg::KIND_RBRACK :
							cttok_pkg::KIND_EQUALS, pos_q, '0, 1'b0, 1'b0);
						n_v = n_v + 2'd1;
					end
					default: begin
						mode_v  = cttok_pkg::MODE_ATOM;
						begin_v = pos_q;
						shape_v = cttok_pkg::shape_next(cttok_pkg::SHAPE_START, c);
					end
				endcase
			end

			if (pos_q != OFF_MAX)
				pos_v = pos_q + OFFSET_BITS'(1);
		end

		// Close the source: flush an open token, then give EOF
		if (src_item.end_of_source) begin
			if (mode_v == cttok_pkg::MODE_ATOM) begin
				bundle_v.tok[n_v] = make_tok(cttok_pkg::KIND_ATOM, begin_v, pos_v - begin_v,
					shape_v == cttok_pkg::SHAPE_INT || shape_v == cttok_pkg::SHAPE_FRAC, 1'b0);
				n_v = n_v + 2'd1;
			end else if (mode_v == cttok_pkg::MODE_STRING) begin
				bundle_v.tok[n_v] = make_tok(cttok_pkg::KIND_STRING, begin_v,
					str_len(pos_v, begin_v), 1'b0, 1'b1);
				n_v = n_v + 2'd1;
			end
			bundle_v.tok[n_v] = make_tok(cttok_pkg::KIND_EOF, pos_v, '0, 1'b0, 1'b0);
			n_v     = n_v + 2'd1;
			mode_v  = cttok_pkg::MODE_IDLE;
			shape_v = cttok_pkg::SHAPE_START;
			pos_v   = '0;
			begin_v = '0;
		end
		bundle_v.count = n_v;
	end

	assign push      = accept && (n_v != 2'd0);
	assign push_data = bundle_v;

	// Hold scan state, advance on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= cttok_pkg::MODE_IDLE;
			shape_q <= cttok_pkg::SHAPE_START;
			pos_q   <= '0;
			begin_q <= '0;
		end else if (accept) begin
			mode_q  <= mode_v;
			shape_q <= shape_v;
			pos_q   <= pos_v;
			begin_q <= begin_v;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/cttok_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cttok_queue - bundle queue
// Small first-in first-out store of token bundles between scanner and
// token sequencer, so that either side can stall on its own.
// ----------------------------------------------------------------------------
module cttok_queue #(
	parameter int QUEUE_DEPTH = cttok_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire cttok_pkg::bundle_t push_data,
	output logic                    full,
	input  wire logic               pop,
	output logic                    not_empty,
	output cttok_pkg::bundle_t      head
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cttok_pkg::bundle_t entry_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_q];

	// Write the bundle at the tail
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_q] <= push_data;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
			if (pop)
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule
`default_nettype wire

// ===== hdl/cttok_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cttok_back - token sequencer
// Walks the tokens of the head bundle one per cycle, while the receiver is
// ready, onto the output channel and marks the last one of each bundle.
// ----------------------------------------------------------------------------
module cttok_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               not_empty,
	input  wire cttok_pkg::bundle_t head,
	output logic                    pop,
	output logic                    tok_valid,
	input  wire logic               tok_ready,
	output cttok_pkg::out_item_t    tok_item
);

	logic [1:0] idx_q;
	logic       last;

	assign last      = (idx_q == head.count - 2'd1);
	assign tok_valid = not_empty;
	assign pop       = tok_valid && tok_ready && last;

	// Select the current token of the bundle
	always_comb begin
		tok_item             = head.tok[idx_q];
		tok_item.last_of_run = last;
	end

	// Step through the bundle, restart on pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (tok_valid && tok_ready) begin
			idx_q <= last ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/config_text_tokenizer_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// config_text_tokenizer_top - streaming config text tokenizer
// Scanner, bundle queue and token sequencer.
// ----------------------------------------------------------------------------
// The block takes one source item per cycle while the queue is not full and
// gives one token per cycle while the receiver is ready. An item that causes
// several tokens (at most three, at end of source) has them sent one after
// another by the token sequencer. The bundle queue of QUEUE_DEPTH entries
// lets the scanner keep accepting bytes while tokens wait; each bundle is
// registered in the queue before its tokens reach the output.
// Offsets are OFFSET_BITS wide and saturate; outputs clamp at 32 bits.
module config_text_tokenizer_top #(
	parameter int OFFSET_BITS = cttok_pkg::OFFSET_BITS_DEF,
	parameter int QUEUE_DEPTH = cttok_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 src_valid,
	output logic                      src_ready,
	input  wire cttok_pkg::in_item_t  src_item,
	output logic                      tok_valid,
	input  wire logic                 tok_ready,
	output cttok_pkg::out_item_t      tok_item
);

	logic               push, pop, full, not_empty;
	cttok_pkg::bundle_t push_data, head;

	cttok_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_item  (src_item),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	cttok_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	cttok_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.head      (head),
		.pop       (pop),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok_item  (tok_item)
	);

endmodule
`default_nettype wire

// ===== hdl/cttok_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cttok_checker - port checks of the tokenizer
// Watches the output channel for stalls and for token field rules.
// ----------------------------------------------------------------------------
module cttok_checker (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 tok_valid,
	input wire logic                 tok_ready,
	input wire cttok_pkg::out_item_t tok_item
);

	// Hold a stalled token
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && !tok_ready |=> tok_valid && $stable(tok_item))
		else $error("token changed while stalled");

	// Only atoms can be numbers
	a_num: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_item.token_kind != cttok_pkg::KIND_ATOM |-> !tok_item.is_number)
		else $error("number flag on non-atom");

	// Only strings can be unterminated
	a_unterm: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_item.unterminated |-> tok_item.token_kind == cttok_pkg::KIND_STRING)
		else $error("unterminated flag on non-string");

	// EOF closes the run of its item
	a_eof: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_item.token_kind == cttok_pkg::KIND_EOF |->
		tok_item.last_of_run && tok_item.text_length == 32'd0)
		else $error("eof token not last or has length");

	// Punctuation carries no text
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_item.token_kind != cttok_pkg::KIND_ATOM &&
		tok_item.token_kind != cttok_pkg::KIND_STRING |-> tok_item.text_length == 32'd0)
		else $error("length on punctuation token");

endmodule

bind config_text_tokenizer_top cttok_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.tok_valid (tok_valid),
	.tok_ready (tok_ready),
	.tok_item  (tok_item)
);
`default_nettype wire

// ===== dv/config_text_tokenizer_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// config_text_tokenizer_checker - token scoreboard for the config tokenizer
// Watches the source and token channels. Each accepted source item runs
// through a scanner model here, and the tokens it causes are queued. Each
// accepted token is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module config_text_tokenizer_checker (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 src_valid,
	input  wire logic                 src_ready,
	input  wire cttok_pkg::in_item_t  src_item,
	input  wire logic                 tok_valid,
	input  wire logic                 tok_ready,
	input  wire cttok_pkg::out_item_t tok_item,
	output int                        mismatches,
	output int                        tokens_due
);
	import cttok_pkg::*;

	// Scanner model state
	mode_t       scan_state;
	shape_t      shape;
	logic [31:0] next_offset;
	logic [31:0] open_start;
	int          made;

	// Tokens predicted but not yet seen on the output
	out_item_t   pending_tokens[$];

	initial mismatches = 0;

	// Print a line for each of the first 100 mismatches and count every one
	task automatic note_mismatch(input string field, input logic [31:0] got,
		input logic [31:0] want);
		if (mismatches < 100) begin
			$display("%0t tokenizer: %s got %0h want %0h", $time, field, got, want);
		end
		mismatches++;
	endtask

	function automatic logic ends_atom(input logic [7:0] c);
		case (c)
			CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_LBRACE, CH_RBRACE, CH_LBRACK,
			CH_RBRACK, CH_EQUALS, CH_QUOTE, CH_HASH: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// Advance the number recogniser; unknown states fall to rejected
	function automatic shape_t step_shape(input shape_t s, input logic [7:0] c);
		logic digit;
		digit = c >= CH_ZERO && c <= CH_NINE;
		if (s == SHAPE_START && c == CH_MINUS) return SHAPE_MINUS;
		if (digit) begin
			if (s == SHAPE_START || s == SHAPE_MINUS || s == SHAPE_INT) return SHAPE_INT;
			if (s == SHAPE_DOT || s == SHAPE_FRAC) return SHAPE_FRAC;
		end
		if (s == SHAPE_INT && c == CH_DOT) return SHAPE_DOT;
		return SHAPE_BAD;
	endfunction

	// Queue one token; an item never causes more than three
	task automatic push_token(input kind_t kind, input logic [31:0] start,
		input logic [31:0] len, input logic num, input logic unterm);
		out_item_t t;
		if (made >= MAX_TOKENS) return;
		t.token_kind   = kind;
		t.start_offset = start;
		t.text_length  = len;
		t.is_number    = num;
		t.unterminated = unterm;
		t.last_of_run  = 1'b0;
		pending_tokens.push_back(t);
		made++;
	endtask

	// String contents exclude the opening quote; never below zero
	function automatic logic [31:0] quote_len(input logic [31:0] stop);
		return (stop > open_start) ? stop - open_start - 32'd1 : 32'd0;
	endfunction

	task automatic close_atom(input logic [31:0] stop);
		push_token(KIND_ATOM, open_start, stop - open_start,
			shape == SHAPE_INT || shape == SHAPE_FRAC, 1'b0);
		scan_state = MODE_IDLE;
	endtask

	// Handle a byte seen between tokens
	task automatic open_token(input logic [7:0] c, input logic [31:0] pos);
		case (c)
			CH_SPACE, CH_TAB, CH_CR, CH_LF: ;
			CH_HASH: scan_state = MODE_COMMENT;
			CH_QUOTE: begin
				scan_state = MODE_STRING;
				open_start = pos;
			end
			CH_LBRACE: push_token(KIND_LBRACE, pos, 32'd0, 1'b0, 1'b0);
			CH_RBRACE: push_token(KIND_RBRACE, pos, 32'd0, 1'b0, 1'b0);
			CH_LBRACK: push_token(KIND_LBRACK, pos, 32'd0, 1'b0, 1'b0);
			CH_RBRACK: push_token(KIND_RBRACK, pos, 32'd0, 1'b0, 1'b0);
			CH_EQUALS: push_token(KIND_EQUALS, pos, 32'd0, 1'b0, 1'b0);
			default: begin
				scan_state = MODE_ATOM;
				open_start = pos;
				shape = step_shape(SHAPE_START, c);
			end
		endcase
	endtask

	task automatic clear_scanner();
		scan_state  = MODE_IDLE;
		shape       = SHAPE_START;
		next_offset = '0;
		open_start  = '0;
	endtask

	// Work out the tokens caused by one source item
	task automatic tokenize_item(input in_item_t it);
		logic [7:0]  c;
		logic [31:0] pos;
		out_item_t   tail;
		made = 0;
		c    = it.text_byte;
		pos  = next_offset;
		if (it.has_byte) begin
			case (scan_state)
				MODE_COMMENT: if (c == CH_LF) scan_state = MODE_IDLE;
				MODE_STRING: begin
					if (c == CH_QUOTE) begin
						push_token(KIND_STRING, open_start, quote_len(pos), 1'b0, 1'b0);
						scan_state = MODE_IDLE;
					end
				end
				MODE_ATOM: begin
					if (ends_atom(c)) begin
						close_atom(pos);
						open_token(c, pos);
					end else begin
						shape = step_shape(shape, c);
					end
				end
				default: open_token(c, pos);
			endcase
			// Offsets saturate at the top of their range
			if (next_offset != '1) next_offset++;
		end
		if (it.end_of_source) begin
			if (scan_state == MODE_ATOM) begin
				close_atom(next_offset);
			end else if (scan_state == MODE_STRING) begin
				push_token(KIND_STRING, open_start, quote_len(next_offset), 1'b0, 1'b1);
			end
			push_token(KIND_EOF, next_offset, 32'd0, 1'b0, 1'b0);
			clear_scanner();
		end
		// Flag the final token of this item
		if (made > 0) begin
			tail = pending_tokens.pop_back();
			tail.last_of_run = 1'b1;
			pending_tokens.push_back(tail);
		end
	endtask

	task automatic check_token(input out_item_t got);
		out_item_t want;
		if (pending_tokens.size() == 0) begin
			note_mismatch("token with none due, kind", 32'(got.token_kind), '0);
			return;
		end
		want = pending_tokens.pop_front();
		if (got.token_kind != want.token_kind)
			note_mismatch("token_kind", 32'(got.token_kind), 32'(want.token_kind));
		if (got.start_offset != want.start_offset)
			note_mismatch("start_offset", got.start_offset, want.start_offset);
		if (got.text_length != want.text_length)
			note_mismatch("text_length", got.text_length, want.text_length);
		if (got.is_number != want.is_number)
			note_mismatch("is_number", 32'(got.is_number), 32'(want.is_number));
		if (got.unterminated != want.unterminated)
			note_mismatch("unterminated", 32'(got.unterminated), 32'(want.unterminated));
		if (got.last_of_run != want.last_of_run)
			note_mismatch("last_of_run", 32'(got.last_of_run), 32'(want.last_of_run));
	endtask

	// Predict on accepted source items, compare accepted tokens
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_scanner();
			pending_tokens.delete();
			tokens_due <= 0;
		end else begin
			if (src_valid && src_ready) tokenize_item(src_item);
			if (tok_valid && tok_ready) check_token(tok_item);
			tokens_due <= pending_tokens.size();
		end
	end

endmodule
`default_nettype wire

// ===== dv/config_text_tokenizer_top_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// config_text_tokenizer_top_tb - testbench of the config text tokenizer
// Feeds a short hand-written source covering every token kind and number
// shape, then about 460 items of random sources built from blanks,
// punctuation, numbers, words, strings, comments and noise, with bursty input
// and a stalling output. A checker beside the block scores every token.
// ----------------------------------------------------------------------------
module config_text_tokenizer_top_tb;
	import cttok_pkg::*;

	localparam int RANDOM_ITEMS = 460;
	localparam int SETTLE       = 20;
	localparam int HOLD_CYCLES  = 250;

	typedef enum int {
		PIECE_BLANK,
		PIECE_PUNCT,
		PIECE_NUMBER,
		PIECE_WORD,
		PIECE_STRING,
		PIECE_COMMENT,
		PIECE_NOISE,
		PIECE_EMPTY
	} piece_t;

	logic      clk;
	logic      arst_n;
	logic      src_valid;
	logic      src_ready;
	in_item_t  src_item;
	logic      tok_valid;
	logic      tok_ready;
	out_item_t tok_item;
	int        mismatches;
	int        tokens_due;

	in_item_t  source_items[$];
	int        planned_items = 0;
	int        items_sent = 0;

	logic [7:0] punct_bytes[5] = '{CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK, CH_EQUALS};
	logic [7:0] blank_bytes[4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};

	config_text_tokenizer_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_item  (src_item),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok_item  (tok_item)
	);

	config_text_tokenizer_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.src_valid  (src_valid),
		.src_ready  (src_ready),
		.src_item   (src_item),
		.tok_valid  (tok_valid),
		.tok_ready  (tok_ready),
		.tok_item   (tok_item),
		.mismatches (mismatches),
		.tokens_due (tokens_due)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Hard stop should the block hang
	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Queue one source item; empty items do not count as stimulus
	task automatic add_item(input logic [7:0] b, input logic has, input logic eos);
		in_item_t it;
		it.text_byte     = b;
		it.has_byte      = has;
		it.end_of_source = eos;
		source_items.push_back(it);
		if (has || eos) planned_items++;
	endtask

	// Receiver: stretches of steady, patchy and mostly stalled ready
	initial begin
		int  span;
		int  style;
		bit  held;
		held = 1'b0;
		tok_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			// Hold off once for long enough to fill the block and stall its input
			if (!held && items_sent >= 200) begin
				held = 1'b1;
				tok_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			style = $urandom_range(0, 3);
			span  = $urandom_range(10, 60);
			repeat (span) begin
				case (style)
					0: tok_ready <= 1'b1;
					1: tok_ready <= 1'($urandom_range(0, 1));
					2: tok_ready <= ($urandom_range(0, 4) == 0);
					default: tok_ready <= ($urandom_range(0, 4) != 0);
				endcase
				@(posedge clk);
			end
		end
	end

	// Sender: build the source items, drive them in bursts, give the verdict
	initial begin
		piece_t     piece;
		in_item_t   tail;
		logic [7:0] c;
		int         pieces;
		int         count;
		int         idx;
		int         burst;
		int         gap;

		src_valid <= 1'b0;
		src_item  <= '0;

		// Hand-written source: every kind, number shapes, byte extremes
		add_item(CH_LBRACE, 1'b1, 1'b0);
		add_item("a", 1'b1, 1'b0);
		add_item(CH_SPACE, 1'b1, 1'b0);
		add_item(CH_EQUALS, 1'b1, 1'b0);
		add_item(CH_MINUS, 1'b1, 1'b0);
		add_item("1", 1'b1, 1'b0);
		add_item(CH_DOT, 1'b1, 1'b0);
		add_item("5", 1'b1, 1'b0);
		add_item(CH_LBRACK, 1'b1, 1'b0);
		add_item(CH_QUOTE, 1'b1, 1'b0);
		add_item("q", 1'b1, 1'b0);
		add_item(CH_QUOTE, 1'b1, 1'b0);
		add_item(CH_RBRACK, 1'b1, 1'b0);
		add_item(CH_RBRACE, 1'b1, 1'b0);
		add_item(8'hFF, 1'b1, 1'b0);
		add_item(8'h00, 1'b1, 1'b0);
		add_item(CH_HASH, 1'b1, 1'b0);
		add_item("z", 1'b1, 1'b0);
		add_item(CH_LF, 1'b1, 1'b0);
		add_item(8'h00, 1'b0, 1'b0);
		add_item(CH_CR, 1'b1, 1'b0);
		// String opened on the last byte: unterminated and empty
		add_item(CH_QUOTE, 1'b1, 1'b1);
		// Atom, brace and end together: three tokens from one item
		add_item("7", 1'b1, 1'b0);
		add_item(CH_LBRACE, 1'b1, 1'b1);
		// End with no byte on an empty source
		add_item(8'h00, 1'b0, 1'b1);
		add_item(CH_HASH, 1'b1, 1'b0);
		add_item(CH_TAB, 1'b1, 1'b1);

		// Random sources of well-formed pieces mixed with noise
		while (planned_items < 27 + RANDOM_ITEMS) begin
			pieces = $urandom_range(1, 12);
			repeat (pieces) begin
				piece = piece_t'($urandom_range(0, PIECE_EMPTY));
				case (piece)
					PIECE_BLANK: add_item(blank_bytes[$urandom_range(0, 3)], 1'b1, 1'b0);
					PIECE_PUNCT: add_item(punct_bytes[$urandom_range(0, 4)], 1'b1, 1'b0);
					PIECE_NUMBER: begin
						if ($urandom_range(0, 2) == 0) add_item(CH_MINUS, 1'b1, 1'b0);
						count = $urandom_range(0, 4);
						repeat (count)
							add_item(8'(CH_ZERO + $urandom_range(0, 9)), 1'b1, 1'b0);
						if ($urandom_range(0, 1)) begin
							add_item(CH_DOT, 1'b1, 1'b0);
							count = $urandom_range(0, 3);
							repeat (count)
								add_item(8'(CH_ZERO + $urandom_range(0, 9)), 1'b1, 1'b0);
						end
					end
					PIECE_WORD: begin
						count = $urandom_range(1, 6);
						repeat (count) begin
							case ($urandom_range(0, 2))
								0: c = 8'("a" + $urandom_range(0, 25));
								1: c = 8'(CH_ZERO + $urandom_range(0, 9));
								default: c = 8'($urandom_range(8'h80, 8'hFF));
							endcase
							add_item(c, 1'b1, 1'b0);
						end
					end
					PIECE_STRING: begin
						add_item(CH_QUOTE, 1'b1, 1'b0);
						count = $urandom_range(0, 6);
						repeat (count) begin
							do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE);
							add_item(c, 1'b1, 1'b0);
						end
						if ($urandom_range(0, 5) != 0) add_item(CH_QUOTE, 1'b1, 1'b0);
					end
					PIECE_COMMENT: begin
						add_item(CH_HASH, 1'b1, 1'b0);
						count = $urandom_range(0, 5);
						repeat (count) add_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
						if ($urandom_range(0, 4) != 0) add_item(CH_LF, 1'b1, 1'b0);
					end
					PIECE_NOISE: add_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
					default: add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
				endcase
			end
			// Close the source on its last byte or with an item of its own
			if ($urandom_range(0, 1)) begin
				tail = source_items.pop_back();
				if (!tail.has_byte && !tail.end_of_source) planned_items++;
				tail.end_of_source = 1'b1;
				source_items.push_back(tail);
			end else begin
				add_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
			end
		end

		@(posedge clk);
		while (!arst_n) @(posedge clk);

		// Offer items in bursts with random gaps between them
		idx = 0;
		while (idx < source_items.size()) begin
			burst = $urandom_range(1, 16);
			while (burst > 0 && idx < source_items.size()) begin
				src_valid <= 1'b1;
				src_item  <= source_items[idx];
				@(posedge clk);
				while (!src_ready) @(posedge clk);
				idx++;
				burst--;
				items_sent++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				src_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		src_valid <= 1'b0;

		// Drain every due token, then let stray output show up
		@(posedge clk);
		while (tokens_due != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);

		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ===== config_text_tokenizer_top.f =====
hdl/cttok_pkg.sv
hdl/cttok_front.sv
hdl/cttok_queue.sv
hdl/cttok_back.sv
hdl/config_text_tokenizer_top.sv
hdl/cttok_checker.sv
dv/config_text_tokenizer_checker.sv
dv/config_text_tokenizer_top_tb.sv
